/* sv/slex_pkg.sv */
// Package for the source lexer: token kinds, scan modes, keyword table and
// character class helpers. No dependencies.
package slex_pkg;

    localparam int OFFSET_BITS_DEF     = 32;
    localparam int KEYWORD_MAX_LEN_DEF = 7;
    localparam int KW_COUNT            = 21;

    localparam logic [5:0] K_DOT     = 6'd7;
    localparam logic [5:0] K_SLASH   = 6'd11;
    localparam logic [5:0] K_BANG    = 6'd14;
    localparam logic [5:0] K_EQUAL   = 6'd16;
    localparam logic [5:0] K_GREATER = 6'd18;
    localparam logic [5:0] K_LESS    = 6'd20;
    localparam logic [5:0] K_IDENT   = 6'd22;
    localparam logic [5:0] K_STRING  = 6'd23;
    localparam logic [5:0] K_NUMBER  = 6'd24;
    localparam logic [5:0] K_KW_BASE = 6'd25;
    localparam logic [5:0] K_EOF     = 6'd46;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNEXP    = 2'd1;
    localparam logic [1:0] ERR_UNTERM   = 2'd2;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_SLASH, M_COMMENT, M_STRING,
        M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC
    } mode_t;

    // keywords, first byte in the low bits, zero padded
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        56'h646e61, 56'h7373616c63, 56'h65736c65, 56'h65736c6166,
        56'h6e7566, 56'h726f66, 56'h6669, 56'h656e6f6e, 56'h726f,
        56'h746e697270, 56'h6e7275746572, 56'h7265707573, 56'h73696874,
        56'h65757274, 56'h726176, 56'h656c696877, 56'h74726f706d69,
        56'h7361, 56'h6863746d61, 56'h65736163, 56'h746c7561666564
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd4, 3'd2, 3'd5, 3'd6,
        3'd5, 3'd4, 3'd4, 3'd3, 3'd5, 3'd6, 3'd2, 3'd5, 3'd4, 3'd7
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    // single-byte punctuation; bit 6 marks a hit
    function automatic logic [6:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28: return {1'b1, 6'd0};
            8'h29: return {1'b1, 6'd1};
            8'h7b: return {1'b1, 6'd2};
            8'h7d: return {1'b1, 6'd3};
            8'h5b: return {1'b1, 6'd4};
            8'h5d: return {1'b1, 6'd5};
            8'h2c: return {1'b1, 6'd6};
            8'h2e: return {1'b1, 6'd7};
            8'h2d: return {1'b1, 6'd8};
            8'h2b: return {1'b1, 6'd9};
            8'h3b: return {1'b1, 6'd10};
            8'h2a: return {1'b1, 6'd12};
            8'h3a: return {1'b1, 6'd13};
            default: return 7'd0;
        endcase
    endfunction

endpackage

/* sv/source_lexer.sv */
// Top level of the source lexer: one byte per word in, up to three tokens
// per byte out. Depends on slex_pkg.
//
// The lexer takes one source byte per cycle while the result buffer is free
// and returns 0..3 tokens for it (tdata kind/start/length/line/err, tlast on
// the last token of that byte). Input words land in a register, combinational
// mode logic turns them into up to three tokens held in a result buffer, and a
// drain counter sends them one per cycle while m_tready is high. With m_tready
// high, the rate is one byte per cycle while each byte makes at most one token;
// a byte that makes two or three tokens holds the input while the buffer drains.
module source_lexer
#(
    parameter int OFFSET_BITS     = slex_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = slex_pkg::KEYWORD_MAX_LEN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_byte[7:0]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // tok_kind[5:0], tok_start, tok_length, tok_line, err_code
    output logic         m_tlast
);
    import slex_pkg::*;

    localparam int CNT_BITS = $clog2(KEYWORD_MAX_LEN + 1);
    localparam int IDX_BITS = $clog2(KEYWORD_MAX_LEN);
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [1:0]  err;
    } tok_t;

    // state
    mode_t                  mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [31:0]            line_reg, line_next;
    logic [7:0]             word_reg [KEYWORD_MAX_LEN];
    logic [7:0]             word_next [KEYWORD_MAX_LEN];
    logic                   long_reg, long_next;
    logic [CNT_BITS-1:0]    wcnt_reg, wcnt_next;

    // input register
    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_char_reg;

    // result buffer
    tok_t       res_reg [3];
    logic [31:0] rline_reg;
    logic [1:0] rcnt_reg;   // tokens in buffer
    logic [1:0] ridx_reg;   // next to send

    tok_t       tok_c [3];
    logic [1:0] ntok_c;
    logic       buf_free, proc;

    assign buf_free = (rcnt_reg == 2'd0) || (m_tready && ridx_reg + 2'd1 == rcnt_reg);
    assign proc     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || proc;

    function automatic logic [31:0] diff(input logic [OFFSET_BITS-1:0] a,
                                         input logic [OFFSET_BITS-1:0] b,
                                         input logic less);
        logic [OFFSET_BITS:0] d;
        d = {1'b0, a} - {1'b0, b} - {{OFFSET_BITS{1'b0}}, less};
        if (d[OFFSET_BITS])
            return 32'd0;
        return 32'(d[OFFSET_BITS-1:0]);
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] p, input logic two);
        logic [5:0] b;
        case (p)
            8'h3d:   b = K_EQUAL;
            8'h3e:   b = K_GREATER;
            8'h3c:   b = K_LESS;
            default: b = K_BANG;
        endcase
        return b + {5'd0, two};
    endfunction

    // keyword match on stored word bytes
    logic [5:0] word_kind;
    always_comb
    begin
        logic hit;
        logic [55:0] w;
        w = '0;
        for (int i = 0; i < 7; i++)
            w[i*8 +: 8] = word_reg[i];
        word_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            hit = !long_reg && wcnt_reg == CNT_BITS'(KW_LEN[k]);
            for (int i = 0; i < 7; i++)
                if (i < int'(KW_LEN[k]) && w[i*8 +: 8] != KW_TEXT[k][i*8 +: 8])
                    hit = 1'b0;
            if (hit)
                word_kind = K_KW_BASE + 6'(k);
        end
    end

    // step logic
    always_comb
    begin
        logic [7:0] c;
        logic consumed;
        logic [6:0] sk;
        logic [OFFSET_BITS-1:0] p;
        c = in_char_reg;
        p = pos_reg;
        consumed = 1'b0;
        mode_next = mode_reg; pend_next = pend_reg; tstart_next = tstart_reg;
        pos_next = pos_reg; line_next = line_reg; long_next = long_reg;
        wcnt_next = wcnt_reg;
        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
            word_next[i] = word_reg[i];
        ntok_c = 2'd0;
        for (int i = 0; i < 3; i++)
            tok_c[i] = '0;
        sk = single_kind(c);
        if (in_func_reg == FUNC_END)
        begin
            unique case (mode_reg)
                M_OP:
                begin
                    tok_c[0] = '{op_kind(pend_reg, 1'b0), 32'(tstart_reg), 32'd1, ERR_NONE};
                    ntok_c = 2'd1;
                end
                M_SLASH:
                begin
                    tok_c[0] = '{K_SLASH, 32'(tstart_reg), 32'd1, ERR_NONE};
                    ntok_c = 2'd1;
                end
                M_STRING:
                begin
                    tok_c[0] = '{K_STRING, 32'(tstart_reg + 1'b1),
                                 diff(p, tstart_reg, 1'b1), ERR_UNTERM};
                    ntok_c = 2'd1;
                end
                M_IDENT:
                begin
                    tok_c[0] = '{word_kind, 32'(tstart_reg), diff(p, tstart_reg, 1'b0), ERR_NONE};
                    ntok_c = 2'd1;
                end
                M_NUM_INT, M_NUM_FRAC:
                begin
                    tok_c[0] = '{K_NUMBER, 32'(tstart_reg), diff(p, tstart_reg, 1'b0), ERR_NONE};
                    ntok_c = 2'd1;
                end
                M_NUM_DOT:
                begin
                    tok_c[0] = '{K_NUMBER, 32'(tstart_reg), diff(p, tstart_reg, 1'b1), ERR_NONE};
                    tok_c[1] = '{K_DOT, (p == '0) ? 32'd0 : 32'(p - 1'b1), 32'd1, ERR_NONE};
                    ntok_c = 2'd2;
                end
                default: ;
            endcase
            tok_c[ntok_c] = '{K_EOF, 32'(p), 32'd0, ERR_NONE};
            ntok_c = ntok_c + 2'd1;
            // back to reset state
            mode_next = M_IDLE; pend_next = '0; tstart_next = '0; pos_next = '0;
            line_next = 32'd1; long_next = 1'b0; wcnt_next = '0;
        end
        else
        begin
            // continue current mode
            unique case (mode_reg)
                M_OP:
                begin
                    mode_next = M_IDLE;
                    tok_c[0] = '{op_kind(pend_reg, c == 8'h3d), 32'(tstart_reg),
                                 (c == 8'h3d) ? 32'd2 : 32'd1, ERR_NONE};
                    ntok_c = 2'd1;
                    consumed = (c == 8'h3d);
                end
                M_SLASH:
                    if (c == 8'h2f)
                    begin
                        mode_next = M_COMMENT;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        tok_c[0] = '{K_SLASH, 32'(tstart_reg), 32'd1, ERR_NONE};
                        ntok_c = 2'd1;
                    end
                M_COMMENT:
                    if (c == 8'h0a)
                        mode_next = M_IDLE;
                    else
                        consumed = 1'b1;
                M_STRING:
                begin
                    consumed = 1'b1;
                    if (c == 8'h22)
                    begin
                        mode_next = M_IDLE;
                        tok_c[0] = '{K_STRING, 32'(tstart_reg + 1'b1),
                                     diff(p, tstart_reg, 1'b1), ERR_NONE};
                        ntok_c = 2'd1;
                    end
                    else if (c == 8'h0a && line_reg != '1)
                        line_next = line_reg + 32'd1;
                end
                M_IDENT:
                    if (is_alpha(c) || is_digit(c))
                    begin
                        consumed = 1'b1;
                        if (wcnt_reg < CNT_BITS'(KEYWORD_MAX_LEN))
                        begin
                            word_next[wcnt_reg[IDX_BITS-1:0]] = c;
                            wcnt_next = wcnt_reg + 1'b1;
                        end
                        else
                            long_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        tok_c[0] = '{word_kind, 32'(tstart_reg),
                                     diff(p, tstart_reg, 1'b0), ERR_NONE};
                        ntok_c = 2'd1;
                    end
                M_NUM_INT:
                    if (is_digit(c))
                        consumed = 1'b1;
                    else if (c == 8'h2e)
                    begin
                        mode_next = M_NUM_DOT;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        tok_c[0] = '{K_NUMBER, 32'(tstart_reg),
                                     diff(p, tstart_reg, 1'b0), ERR_NONE};
                        ntok_c = 2'd1;
                    end
                M_NUM_DOT:
                    if (is_digit(c))
                    begin
                        mode_next = M_NUM_FRAC;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        tok_c[0] = '{K_NUMBER, 32'(tstart_reg),
                                     diff(p, tstart_reg, 1'b1), ERR_NONE};
                        tok_c[1] = '{K_DOT, (p == '0) ? 32'd0 : 32'(p - 1'b1),
                                     32'd1, ERR_NONE};
                        ntok_c = 2'd2;
                    end
                M_NUM_FRAC:
                    if (is_digit(c))
                        consumed = 1'b1;
                    else
                    begin
                        mode_next = M_IDLE;
                        tok_c[0] = '{K_NUMBER, 32'(tstart_reg),
                                     diff(p, tstart_reg, 1'b0), ERR_NONE};
                        ntok_c = 2'd1;
                    end
                default: ;
            endcase
            // start a fresh token
            if (!consumed)
            begin
                tstart_next = p;
                if (sk[6])
                begin
                    tok_c[ntok_c] = '{sk[5:0], 32'(p), 32'd1, ERR_NONE};
                    ntok_c = ntok_c + 2'd1;
                end
                else if (c == 8'h21 || c == 8'h3d || c == 8'h3c || c == 8'h3e)
                begin
                    pend_next = c;
                    mode_next = M_OP;
                end
                else if (c == 8'h2f)
                    mode_next = M_SLASH;
                else if (c == 8'h20 || c == 8'h0d || c == 8'h09)
                    ;
                else if (c == 8'h0a)
                begin
                    if (line_reg != '1)
                        line_next = line_reg + 32'd1;
                end
                else if (c == 8'h22)
                    mode_next = M_STRING;
                else if (is_digit(c))
                    mode_next = M_NUM_INT;
                else if (is_alpha(c))
                begin
                    mode_next = M_IDENT;
                    long_next = 1'b0;
                    word_next[0] = c;
                    wcnt_next = CNT_BITS'(1);
                end
                else
                begin
                    tok_c[ntok_c] = '{6'd0, 32'(p), 32'd1, ERR_UNEXP};
                    ntok_c = ntok_c + 2'd1;
                end
            end
            if (p != POS_MAX)
                pos_next = p + 1'b1;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pend_reg   <= '0;
            tstart_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= 32'd1;
            long_reg   <= 1'b0;
            wcnt_reg   <= '0;
        end
        else if (proc)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            long_reg   <= long_next;
            wcnt_reg   <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
            for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                word_reg[i] <= word_next[i];
    end

    // result buffer and drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= '0;
            ridx_reg <= '0;
        end
        else if (proc)
        begin
            rcnt_reg <= ntok_c;
            ridx_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (ridx_reg + 2'd1 == rcnt_reg)
            begin
                rcnt_reg <= '0;
                ridx_reg <= '0;
            end
            else
                ridx_reg <= ridx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= tok_c[i];
            rline_reg <= line_reg;
        end
    end

    // line is taken before the step: no token follows a newline within one byte,
    // and eof keeps the pre-reset count
    logic [31:0] out_line;
    tok_t        cur;
    assign cur      = res_reg[ridx_reg];
    assign out_line = rline_reg;
    assign m_tvalid = rcnt_reg != 2'd0;
    assign m_tlast  = ridx_reg + 2'd1 == rcnt_reg;
    assign m_tdata  = {cur.err, out_line, cur.len, cur.start, cur.kind};

endmodule

/* sv/slex_checker.sv */
// Port-level checker for the source lexer, bound to the top level.
// Depends on the top level's ports only.
module slex_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);
    // kind stays in range
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:0] <= 6'd46) else $error("kind out of range");

    // eof word always closes its run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:0] == 6'd46 |-> m_tlast) else $error("eof not last");

    // error code only on unexpected character or string
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[103:102] != 2'd0 |->
        (m_tdata[5:0] == 6'd0 || m_tdata[5:0] == 6'd23)) else $error("bad err");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_tvalid && !m_tready) |-> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");

endmodule

bind source_lexer slex_checker u_slex_checker (.*);

/* verif/source_lexer_tb.sv */
// Testbench for source_lexer: directed and random byte streams are checked
// against a token predictor kept in step with the stream. Depends on slex_pkg and source_lexer.
`timescale 1ns / 1ps

module source_lexer_tb;
    import slex_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic [1:0]  err;
        logic        last;
    } token_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;

    token_t tokens_due[$];
    int     fail_count;
    int     words_sent;
    int     src_idle;
    int     snk_idle;
    int     quiet_cycles;

    // predictor state
    mode_t           lx_mode;
    logic [7:0]      lx_op;
    longint unsigned lx_tstart;
    longint unsigned lx_pos;
    int unsigned     lx_line;
    logic [7:0]      lx_word [KEYWORD_MAX_LEN_DEF];
    bit              lx_long;
    int              lx_wcount;

    source_lexer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic void lexer_clear();
        lx_mode   = M_IDLE;
        lx_op     = 8'd0;
        lx_tstart = 0;
        lx_pos    = 0;
        lx_line   = 1;
        lx_long   = 1'b0;
        lx_wcount = 0;
    endfunction

    function automatic void add_token(input logic [5:0] kind, input longint unsigned start,
                                      input longint unsigned len, input logic [1:0] err);
        token_t t;
        t.kind  = kind;
        t.start = start[31:0];
        t.len   = len[31:0];
        t.line  = lx_line;
        t.err   = err;
        t.last  = 1'b0;
        tokens_due.push_back(t);
    endfunction

    function automatic longint unsigned span(input longint unsigned a,
                                             input longint unsigned b, input int less);
        if (a < b + less || b > a)
            return 0;
        return a - b - less;
    endfunction

    function automatic void bump_line();
        if (lx_line != 32'hFFFF_FFFF)
            lx_line++;
    endfunction

    function automatic logic [5:0] op_token(input bit pair);
        logic [5:0] base;
        case (lx_op)
            "=":     base = K_EQUAL;
            ">":     base = K_GREATER;
            "<":     base = K_LESS;
            default: base = K_BANG;
        endcase
        return pair ? base + 6'd1 : base;
    endfunction

    function automatic void close_word(input longint unsigned stop);
        logic [5:0] kind;
        bit         same;
        kind = K_IDENT;
        if (!lx_long) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (kind == K_IDENT && KW_LEN[k] == lx_wcount) begin
                    same = 1'b1;
                    for (int i = 0; i < lx_wcount; i++)
                        if (lx_word[i] != KW_TEXT[k][8*i +: 8])
                            same = 1'b0;
                    if (same)
                        kind = K_KW_BASE + 6'(k);
                end
            end
        end
        add_token(kind, lx_tstart, span(stop, lx_tstart, 0), ERR_NONE);
    endfunction

    function automatic void close_number_dot(input longint unsigned stop);
        add_token(K_NUMBER, lx_tstart, span(stop, lx_tstart, 1), ERR_NONE);
        add_token(K_DOT, stop == 0 ? 0 : stop - 1, 1, ERR_NONE);
    endfunction

    // carry on the open token; return 1 when the byte is used up
    function automatic bit lexer_continue(input logic [7:0] c, input longint unsigned pos);
        case (lx_mode)
            M_OP:
            begin
                lx_mode = M_IDLE;
                if (c == "=")
                begin
                    add_token(op_token(1'b1), lx_tstart, 2, ERR_NONE);
                    return 1'b1;
                end
                add_token(op_token(1'b0), lx_tstart, 1, ERR_NONE);
                return 1'b0;
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    lx_mode = M_COMMENT;
                    return 1'b1;
                end
                lx_mode = M_IDLE;
                add_token(K_SLASH, lx_tstart, 1, ERR_NONE);
                return 1'b0;
            end
            M_COMMENT:
            begin
                if (c == 8'h0a)
                begin
                    lx_mode = M_IDLE;
                    return 1'b0;
                end
                return 1'b1;
            end
            M_STRING:
            begin
                if (c == 8'h22)
                begin
                    lx_mode = M_IDLE;
                    add_token(K_STRING, lx_tstart + 1, span(pos, lx_tstart, 1), ERR_NONE);
                end
                else if (c == 8'h0a)
                    bump_line();
                return 1'b1;
            end
            M_IDENT:
            begin
                if (is_alpha(c) || is_digit(c))
                begin
                    if (lx_wcount < KEYWORD_MAX_LEN_DEF)
                    begin
                        lx_word[lx_wcount] = c;
                        lx_wcount++;
                    end
                    else
                        lx_long = 1'b1;
                    return 1'b1;
                end
                lx_mode = M_IDLE;
                close_word(pos);
                return 1'b0;
            end
            M_NUM_INT:
            begin
                if (is_digit(c))
                    return 1'b1;
                if (c == ".")
                begin
                    lx_mode = M_NUM_DOT;
                    return 1'b1;
                end
                lx_mode = M_IDLE;
                add_token(K_NUMBER, lx_tstart, span(pos, lx_tstart, 0), ERR_NONE);
                return 1'b0;
            end
            M_NUM_DOT:
            begin
                if (is_digit(c))
                begin
                    lx_mode = M_NUM_FRAC;
                    return 1'b1;
                end
                lx_mode = M_IDLE;
                close_number_dot(pos);
                return 1'b0;
            end
            M_NUM_FRAC:
            begin
                if (is_digit(c))
                    return 1'b1;
                lx_mode = M_IDLE;
                add_token(K_NUMBER, lx_tstart, span(pos, lx_tstart, 0), ERR_NONE);
                return 1'b0;
            end
            default:
            begin
                lx_mode = M_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void lexer_begin(input logic [7:0] c, input longint unsigned pos);
        logic [6:0] punct;
        punct     = single_kind(c);
        lx_tstart = pos;
        if (punct[6])
            add_token(punct[5:0], pos, 1, ERR_NONE);
        else if (c == "!" || c == "=" || c == "<" || c == ">")
        begin
            lx_op   = c;
            lx_mode = M_OP;
        end
        else if (c == "/")
            lx_mode = M_SLASH;
        else if (c == " " || c == 8'h0d || c == 8'h09)
            ;
        else if (c == 8'h0a)
            bump_line();
        else if (c == 8'h22)
            lx_mode = M_STRING;
        else if (is_digit(c))
            lx_mode = M_NUM_INT;
        else if (is_alpha(c))
        begin
            lx_mode    = M_IDENT;
            lx_long    = 1'b0;
            lx_word[0] = c;
            lx_wcount  = 1;
        end
        else
            add_token(6'd0, pos, 1, ERR_UNEXP);
    endfunction

    function automatic void lexer_finish();
        longint unsigned stop;
        stop = lx_pos;
        case (lx_mode)
            M_OP:       add_token(op_token(1'b0), lx_tstart, 1, ERR_NONE);
            M_SLASH:    add_token(K_SLASH, lx_tstart, 1, ERR_NONE);
            M_STRING:   add_token(K_STRING, lx_tstart + 1, span(stop, lx_tstart, 1), ERR_UNTERM);
            M_IDENT:    close_word(stop);
            M_NUM_INT,
            M_NUM_FRAC: add_token(K_NUMBER, lx_tstart, span(stop, lx_tstart, 0), ERR_NONE);
            M_NUM_DOT:  close_number_dot(stop);
            default:    ;
        endcase
        add_token(K_EOF, stop, 0, ERR_NONE);
    endfunction

    // work out the tokens that one accepted word produces
    function automatic void predict_tokens(input logic f, input logic [7:0] c);
        int before_n;
        before_n = tokens_due.size();
        if (f == FUNC_END)
            lexer_finish();
        else
        begin
            if (!lexer_continue(c, lx_pos))
                lexer_begin(c, lx_pos);
            if (lx_pos < 64'hFFFF_FFFF)
                lx_pos++;
        end
        if (tokens_due.size() > before_n)
            tokens_due[tokens_due.size() - 1].last = 1'b1;
        if (f == FUNC_END)
            lexer_clear();
    endfunction

    // ---------------- sender side ----------------
    task automatic send_word(input logic f, input logic [7:0] c);
        bit hit;
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= c;
        do
        begin
            @(negedge clk);
            hit = s_tready;
            @(posedge clk);
        end
        while (!hit);
        predict_tokens(f, c);
        words_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_word(FUNC_BYTE, txt[i]);
    endtask

    // hold the sender until every token due has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------- receiver side and checks ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= $urandom_range(99) >= snk_idle;
    end

    always @(negedge clk)
    begin
        token_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("token with none due: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (m_tdata[5:0] !== want.kind)
                begin
                    $error("tok_kind: expected %0d, got %0d", want.kind, m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[37:6] !== want.start)
                begin
                    $error("tok_start: expected %0d, got %0d", want.start, m_tdata[37:6]);
                    fail_count++;
                end
                if (m_tdata[69:38] !== want.len)
                begin
                    $error("tok_length: expected %0d, got %0d", want.len, m_tdata[69:38]);
                    fail_count++;
                end
                if (m_tdata[101:70] !== want.line)
                begin
                    $error("tok_line: expected %0d, got %0d", want.line, m_tdata[101:70]);
                    fail_count++;
                end
                if (m_tdata[103:102] !== want.err)
                begin
                    $error("err_code: expected %0d, got %0d", want.err, m_tdata[103:102]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_punctuation();
        send_text("(){}[],.-+;*:");
        send_text("! != = == > >= < <=/ /");
        send_word(FUNC_END, 8'h00);
    endtask

    task automatic test_comments_numbers();
        send_text("//c\n7 1.5 3.x 12.");
        send_word(FUNC_END, 8'hFF);
    endtask

    task automatic test_words_strings();
        send_text("while whilex default abcdefghij _Z9 ");
        send_text("\"a\nb\" \"open");
        send_word(FUNC_END, 8'h5A);
    endtask

    task automatic test_odd_bytes();
        send_word(FUNC_BYTE, 8'h00);
        send_word(FUNC_BYTE, 8'hFF);
        send_word(FUNC_BYTE, 8'h80);
        send_word(FUNC_BYTE, "@");
        send_word(FUNC_BYTE, "=");
        send_word(FUNC_END, 8'h00);
        send_word(FUNC_BYTE, "/");
        send_word(FUNC_END, 8'h00);
        send_word(FUNC_BYTE, "1");
        send_word(FUNC_BYTE, ".");
        send_word(FUNC_END, 8'h00);
    endtask

    // one random lexeme, mostly well formed
    task automatic send_lexeme();
        string punct;
        int    pick;
        int    k;
        int    n;
        punct = "(){}[],.-+;*:!=<>/";
        pick  = $urandom_range(99);
        if (pick < 18)
        begin
            k = $urandom_range(KW_COUNT - 1);
            for (int i = 0; i < KW_LEN[k]; i++)
                send_word(FUNC_BYTE, KW_TEXT[k][8*i +: 8]);
        end
        else if (pick < 30)
        begin
            n = $urandom_range(1, 10);
            send_word(FUNC_BYTE, 8'("a" + $urandom_range(25)));
            for (int i = 1; i < n; i++)
                send_word(FUNC_BYTE, $urandom_range(1) ? 8'("0" + $urandom_range(9))
                                                       : 8'("_"));
        end
        else if (pick < 42)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                send_word(FUNC_BYTE, 8'("0" + $urandom_range(9)));
            if ($urandom_range(1))
            begin
                send_word(FUNC_BYTE, ".");
                if ($urandom_range(2) != 0)
                    send_word(FUNC_BYTE, 8'("0" + $urandom_range(9)));
            end
        end
        else if (pick < 50)
        begin
            send_word(FUNC_BYTE, 8'h22);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                send_word(FUNC_BYTE, $urandom_range(5) == 0 ? 8'h0a
                                                            : 8'("a" + $urandom_range(25)));
            if ($urandom_range(5) != 0)
                send_word(FUNC_BYTE, 8'h22);
        end
        else if (pick < 70)
        begin
            send_word(FUNC_BYTE, punct[$urandom_range(punct.len() - 1)]);
            if ($urandom_range(1))
                send_word(FUNC_BYTE, "=");
        end
        else if (pick < 75)
        begin
            send_text("//");
            send_word(FUNC_BYTE, 8'($urandom_range(255)));
            send_word(FUNC_BYTE, 8'h0a);
        end
        else if (pick < 88)
        begin
            send_word(FUNC_BYTE, $urandom_range(1) ? 8'h20 : ($urandom_range(1) ? 8'h0a : 8'h09));
        end
        else if (pick < 96)
            send_word(FUNC_BYTE, 8'($urandom_range(255)));
        else
            send_word(FUNC_END, 8'($urandom_range(255)));
    endtask

    task automatic test_random(input int src_pct, input int snk_pct, input int count);
        int goal;
        src_idle = src_pct;
        snk_idle = snk_pct;
        goal     = words_sent + count;
        while (words_sent < goal)
            send_lexeme();
        send_word(FUNC_END, 8'($urandom_range(255)));
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tuser      = FUNC_BYTE;
        m_tready     = 1'b0;
        fail_count   = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        src_idle     = 14;
        snk_idle     = 50;
        lexer_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_punctuation();
        test_comments_numbers();
        test_words_strings();
        test_odd_bytes();
        test_random(14, 50, 55);
        drain();
        test_random(50, 14, 55);
        test_random(0, 0, 55);
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/slex_pkg.sv
sv/source_lexer.sv
sv/slex_checker.sv
verif/source_lexer_tb.sv
